// ===== rtl/core/fpa_pkg.sv =====
// Shared types and constants for the Q24.8 fixed-point ALU.
`default_nettype none
package fpa_pkg;

  localparam int WORD_BITS          = 32;
  localparam int CMD_BITS           = 4;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 8;
  localparam int DIV_STEPS          = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic dz;
  } div_side_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic cmp;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/fpa_div_stage.sv =====
// One register stage of the restoring divider, retiring up to DIV_STEPS quotient bits.
`default_nettype none
module fpa_div_stage #(
  parameter int DW    = 32,
  parameter int QW    = 40,
  parameter int FIRST = 0
) (
  input  wire logic                   clk,
  input  wire logic [DW:0]            rem_in,
  input  wire logic [QW-1:0]          dq_in,
  input  wire logic [DW-1:0]          d_in,
  input  wire fpa_pkg::div_side_t     side_in,
  output logic      [DW:0]            rem_out,
  output logic      [QW-1:0]          dq_out,
  output logic      [DW-1:0]          d_out,
  output fpa_pkg::div_side_t          side_out
);
  import fpa_pkg::*;

  logic [DW:0]   rem_next;
  logic [QW-1:0] dq_next;

  // Dividend bits shift out of the top of dq while quotient bits shift in below.
  always_comb begin
    rem_next = rem_in;
    dq_next  = dq_in;
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (FIRST + j < QW) begin
        rem_next = {rem_next[DW-1:0], dq_next[QW-1]};
        dq_next  = {dq_next[QW-2:0], 1'b0};
        if (rem_next >= {1'b0, d_in}) begin
          rem_next   = rem_next - {1'b0, d_in};
          dq_next[0] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_out  <= rem_next;
    dq_out   <= dq_next;
    d_out    <= d_in;
    side_out <= side_in;
  end

endmodule
`default_nettype wire

// ===== rtl/core/fpa_divider.sv =====
// Pipelined signed fixed-point divider: magnitude setup, divide stages, sign fix.
`default_nettype none
module fpa_divider #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic signed [DATA_WIDTH-1:0] a,
  input  wire logic signed [DATA_WIDTH-1:0] b,
  output logic      signed [DATA_WIDTH-1:0] quotient,
  output fpa_pkg::div_side_t                side
);
  import fpa_pkg::*;

  localparam int QW  = DATA_WIDTH + FRAC_BITS;
  localparam int NST = (QW + DIV_STEPS - 1) / DIV_STEPS;

  logic [DATA_WIDTH:0]   rem_s  [NST+1];
  logic [QW-1:0]         dq_s   [NST+1];
  logic [DATA_WIDTH-1:0] d_s    [NST+1];
  div_side_t             side_s [NST+1];

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH-1:0] q_mag;

  assign mag_a = a[DATA_WIDTH-1] ? -a : a;
  assign mag_b = b[DATA_WIDTH-1] ? -b : b;

  always_ff @(posedge clk) begin
    rem_s[0]     <= '0;
    dq_s[0]      <= {mag_a, {FRAC_BITS{1'b0}}};
    d_s[0]       <= mag_b;
    side_s[0].neg <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    side_s[0].dz  <= (b == '0);
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    fpa_div_stage #(
      .DW    (DATA_WIDTH),
      .QW    (QW),
      .FIRST (s * DIV_STEPS)
    ) u_stage (
      .clk      (clk),
      .rem_in   (rem_s[s]),
      .dq_in    (dq_s[s]),
      .d_in     (d_s[s]),
      .side_in  (side_s[s]),
      .rem_out  (rem_s[s+1]),
      .dq_out   (dq_s[s+1]),
      .d_out    (d_s[s+1]),
      .side_out (side_s[s+1])
    );
  end

  // Only the low word of the quotient survives the wrap, so negate just that.
  assign q_mag    = dq_s[NST][DATA_WIDTH-1:0];
  assign side     = side_s[NST];
  assign quotient = side_s[NST].dz ? '0 : (side_s[NST].neg ? -q_mag : q_mag);

endmodule
`default_nettype wire

// ===== rtl/core/fpa_basic_ops.sv =====
// Two-stage datapath for every opcode but divide: multiply and other ops, then result select.
`default_nettype none
module fpa_basic_ops #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid_in,
  input  wire logic [fpa_pkg::CMD_BITS-1:0] cmd,
  input  wire logic signed [DATA_WIDTH-1:0] a,
  input  wire logic signed [DATA_WIDTH-1:0] b,
  output logic      signed [DATA_WIDTH-1:0] word,
  output fpa_pkg::pipe_ctl_t                ctl
);
  import fpa_pkg::*;

  logic signed [2*DATA_WIDTH-1:0] prod;
  logic signed [2*DATA_WIDTH-1:0] prod_shift;
  logic signed [DATA_WIDTH-1:0]   word_s1;
  logic signed [DATA_WIDTH-1:0]   word_next;
  logic                           is_mul;
  logic                           cmp_next;
  pipe_ctl_t                      ctl_s1;

  always_comb begin
    word_next = '0;
    cmp_next  = 1'b0;
    unique case (cmd_t'(cmd))
      CMD_ADD:      word_next = a + b;
      CMD_SUB:      word_next = a - b;
      CMD_MUL:      word_next = '0;
      CMD_DIV:      word_next = '0;
      CMD_GT:       cmp_next  = (a > b);
      CMD_LT:       cmp_next  = (a < b);
      CMD_GE:       cmp_next  = (a >= b);
      CMD_LE:       cmp_next  = (a <= b);
      CMD_EQ:       cmp_next  = (a == b);
      CMD_NE:       cmp_next  = (a != b);
      CMD_MIN:      word_next = (a < b) ? a : b;
      CMD_MAX:      word_next = (a > b) ? a : b;
      CMD_INC:      word_next = a + 1'b1;
      CMD_DEC:      word_next = a - 1'b1;
      CMD_FROM_INT: word_next = a << FRAC_BITS;
      CMD_TO_INT:   word_next = a >>> FRAC_BITS;
      default:      word_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s1.valid <= 1'b0;
      ctl          <= '0;
    end else begin
      ctl_s1.valid <= valid_in;
      ctl          <= ctl_s1;
    end
    ctl_s1.is_div <= (cmd_t'(cmd) == CMD_DIV);
    ctl_s1.cmp    <= cmp_next;
    is_mul        <= (cmd_t'(cmd) == CMD_MUL);
    prod          <= a * b;
    word_s1       <= word_next;
    word          <= is_mul ? prod_shift[DATA_WIDTH-1:0] : word_s1;
  end

  assign prod_shift = prod >>> FRAC_BITS;

endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_alu_q24_8.sv =====
// Top level of the pipelined signed fixed-point ALU.
// Usage: drive cmd, operand_a and operand_b with start high; the word is taken
// at any rising edge where start is high and busy is low. busy stays low, so a
// new word may be issued on every clock cycle.
// Each issued word yields exactly one result word, presented on result_word,
// compare_true and divide_by_zero for one cycle while done is high, in issue
// order. The receiver takes it at that edge and cannot stall the pipeline.
// Each word passes the input register, then the divider or the basic datapath
// and its delay line, then the output register; throughput is one word per
// cycle. The restoring divider retires two quotient bits in each register
// stage; the basic datapath and its delay line together match its length.
// Only the low DATA_WIDTH bits of each operand are used, read as signed; the
// result is sign-extended to 32 bits.
// A synchronous reset clears all valid bits, so done is low after reset and
// words in flight are dropped.
`default_nettype none
module fixed_point_alu_q24_8 #(
  parameter int DATA_WIDTH = fpa_pkg::DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = fpa_pkg::FRAC_BITS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [fpa_pkg::CMD_BITS-1:0]  cmd,
  input  wire logic signed [fpa_pkg::WORD_BITS-1:0] operand_a,
  input  wire logic signed [fpa_pkg::WORD_BITS-1:0] operand_b,
  output logic                                      done,
  output logic signed      [fpa_pkg::WORD_BITS-1:0] result_word,
  output logic                                      compare_true,
  output logic                                      divide_by_zero
);
  import fpa_pkg::*;

  localparam int QW  = DATA_WIDTH + FRAC_BITS;
  localparam int NST = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DLY = NST - 1;

  logic                         in_valid;
  logic [CMD_BITS-1:0]          cmd_r;
  logic signed [DATA_WIDTH-1:0] a_r;
  logic signed [DATA_WIDTH-1:0] b_r;

  logic signed [DATA_WIDTH-1:0] basic_word;
  pipe_ctl_t                    basic_ctl;
  logic signed [DATA_WIDTH-1:0] div_q;
  div_side_t                    div_side;

  logic signed [DATA_WIDTH-1:0] dly_word [DLY];
  pipe_ctl_t                    dly_ctl  [DLY];

  logic signed [DATA_WIDTH-1:0] final_word;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    cmd_r <= cmd;
    a_r   <= operand_a[DATA_WIDTH-1:0];
    b_r   <= operand_b[DATA_WIDTH-1:0];
  end

  fpa_basic_ops #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_basic (
    .clk      (clk),
    .rst      (rst),
    .valid_in (in_valid),
    .cmd      (cmd_r),
    .a        (a_r),
    .b        (b_r),
    .word     (basic_word),
    .ctl      (basic_ctl)
  );

  fpa_divider #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .a        (a_r),
    .b        (b_r),
    .quotient (div_q),
    .side     (div_side)
  );

  // Delay line that lines the non-divide results up with the divider output.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        dly_ctl[i] <= '0;
      end
    end else begin
      dly_ctl[0] <= basic_ctl;
      for (int i = 1; i < DLY; i++) begin
        dly_ctl[i] <= dly_ctl[i-1];
      end
    end
    dly_word[0] <= basic_word;
    for (int i = 1; i < DLY; i++) begin
      dly_word[i] <= dly_word[i-1];
    end
  end

  assign final_word = dly_ctl[DLY-1].is_div ? div_q : dly_word[DLY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dly_ctl[DLY-1].valid;
    end
    result_word    <= WORD_BITS'(final_word);
    compare_true   <= dly_ctl[DLY-1].cmp;
    divide_by_zero <= dly_ctl[DLY-1].is_div & div_side.dz;
  end

endmodule
`default_nettype wire

// ===== verif/tb_fixed_point_alu_q24_8.sv =====
// Self-checking testbench for the pipelined Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
module tb_fixed_point_alu_q24_8;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 23;
  localparam int RANDOM_WORDS = 2000;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct {
    logic [31:0] word;
    logic        cmp;
    logic        dz;
  } alu_out_t;

  typedef struct {
    cmd_t        op;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    alu_out_t    out;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] cmd = 4'd0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic busy, done, compare_true, divide_by_zero;
  logic signed [31:0] result_word;

  alu_out_t pending_results[$];
  int mismatches = 0;
  longint cycles = 0;

  fixed_point_alu_q24_8 DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result_word(result_word), .compare_true(compare_true),
    .divide_by_zero(divide_by_zero)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic alu_out_t compute_alu(cmd_t op, logic [31:0] ra, logic [31:0] rb);
    alu_out_t o;
    longint a, b, r;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    r = 0;
    o.cmp = 1'b0;
    o.dz = 1'b0;
    case (op)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = (a * b) >>> FRAC;
      CMD_DIV: begin
        if (b == 0) o.dz = 1'b1;
        else r = (a * 256) / b;  // SV integer divide truncates toward zero
      end
      CMD_GT: o.cmp = a > b;
      CMD_LT: o.cmp = a < b;
      CMD_GE: o.cmp = a >= b;
      CMD_LE: o.cmp = a <= b;
      CMD_EQ: o.cmp = a == b;
      CMD_NE: o.cmp = a != b;
      CMD_MIN: r = (a < b) ? a : b;
      CMD_MAX: r = (a > b) ? a : b;
      CMD_INC: r = a + 1;
      CMD_DEC: r = a - 1;
      CMD_FROM_INT: r = a * 256;
      default: r = a >>> FRAC;
    endcase
    o.word = r[31:0];
    return o;
  endfunction

  // Results are checked at the rising edge, in issue order.
  always @(posedge clk) begin
    alu_out_t exp_out;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("Unexpected result word %h", result_word);
      end else begin
        exp_out = pending_results.pop_front();
        if (result_word !== exp_out.word || compare_true !== exp_out.cmp ||
            divide_by_zero !== exp_out.dz) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("Mismatch: expected %h/%b/%b, got %h/%b/%b", exp_out.word,
                     exp_out.cmp, exp_out.dz, result_word, compare_true, divide_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Issues one word and holds it until the edge that accepts it.
  task automatic issue_word(cmd_t op, logic [31:0] a, logic [31:0] b, alu_out_t exp_out);
    start <= 1'b1;
    cmd <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (busy);
    pending_results.push_back(exp_out);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0100;
      4: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    alu_out_t exp_out;
    cmd_t op;
    logic [31:0] a, b;
    int burst, waited;

    rows = '{
      '{CMD_ADD, 32'h7fff_ffff, 32'h0000_0001, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_SUB, 32'h8000_0000, 32'h0000_0001, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
      '{CMD_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0, '{0, 0, 0}},
      '{CMD_MUL, 32'hffff_ff00, 32'h0000_0080, 1'b0, '{0, 0, 0}},
      '{CMD_MUL, 32'h7fff_ffff, 32'h8000_0000, 1'b0, '{0, 0, 0}},
      '{CMD_DIV, 32'h1234_5678, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b1}},
      '{CMD_DIV, 32'h8000_0000, 32'hffff_ff00, 1'b0, '{0, 0, 0}},
      '{CMD_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0, '{0, 0, 0}},
      '{CMD_DIV, 32'hffff_fd00, 32'h0000_0700, 1'b0, '{0, 0, 0}},
      '{CMD_DIV, 32'h7fff_ffff, 32'h0000_0001, 1'b0, '{0, 0, 0}},
      '{CMD_GT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
      '{CMD_LT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0}},
      '{CMD_GE, 32'h0000_0005, 32'h0000_0005, 1'b1, '{32'h0, 1'b1, 1'b0}},
      '{CMD_LE, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
      '{CMD_EQ, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b1, 1'b0}},
      '{CMD_NE, 32'hffff_ffff, 32'hffff_ffff, 1'b1, '{32'h0, 1'b0, 1'b0}},
      '{CMD_MIN, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_MAX, 32'h8000_0000, 32'h7fff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
      '{CMD_INC, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_DEC, 32'h8000_0000, 32'hffff_ffff, 1'b1, '{32'h7fff_ffff, 1'b0, 1'b0}},
      '{CMD_FROM_INT, 32'h0080_0000, 32'h0, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      '{CMD_TO_INT, 32'hffff_ffff, 32'h0, 1'b1, '{32'hffff_ffff, 1'b0, 1'b0}},
      '{CMD_TO_INT, 32'h8000_0000, 32'h0, 1'b1, '{32'hff80_0000, 1'b0, 1'b0}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      exp_out = rows[i].typed ? rows[i].out : compute_alu(rows[i].op, rows[i].a, rows[i].b);
      issue_word(rows[i].op, rows[i].a, rows[i].b, exp_out);
    end
    start <= 1'b0;

    // Let the pipeline drain once before the random bursts.
    while (pending_results.size() != 0) @(negedge clk);

    for (int n = 0; n < RANDOM_WORDS; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < RANDOM_WORDS; k++, n++) begin
        op = cmd_t'($urandom_range(0, 15));
        a = rand_operand();
        b = (op == CMD_DIV && $urandom_range(0, 15) == 0) ? 32'h0 : rand_operand();
        issue_word(op, a, b, compute_alu(op, a, b));
      end
      if ($urandom_range(0, 2) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
    start <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < 10 * LATENCY) begin
      @(negedge clk);
      waited++;
    end
    repeat (LATENCY + 5) @(negedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
